[rtl/core/lws_pkg.sv]
// lws_pkg: shared types, codes and constants for the lcd 4-bit write sequencer
// used by lws_front, lws_queue, lws_back and lcd_4bit_write_sequencer
package lws_pkg;

   localparam int TICK_W     = 10;
   localparam int CFG_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int INIT_STEPS = 7;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] REQ_TICK = 3'd0;
   localparam logic [2:0] REQ_CMD  = 3'd1;
   localparam logic [2:0] REQ_CHAR = 3'd2;
   localparam logic [2:0] REQ_INIT = 3'd3;
   localparam logic [2:0] REQ_POS  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_CMD_PULSE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_PULSE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POWERUP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_TAIL  = 3'd4;

   localparam logic [CFG_W-1:0] RST_CMD_PULSE  = 10'd1;
   localparam logic [CFG_W-1:0] RST_DATA_PULSE = 10'd10;
   localparam logic [CFG_W-1:0] RST_SETTLE     = 10'd5;
   localparam logic [CFG_W-1:0] RST_POWERUP    = 10'd100;
   localparam logic [CFG_W-1:0] RST_INIT_TAIL  = 10'd20;

   localparam logic [7:0] ROW0_BASE = 8'h80;
   localparam logic [7:0] ROW1_BASE = 8'hC0;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_TICK = 2'd1,
      OP_LOAD = 2'd2,
      OP_INIT = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic       rs;
   } item_type;

   typedef enum logic [7:0] {
      PH_IDLE     = 8'b0000_0001,
      PH_POWERUP  = 8'b0000_0010,
      PH_SETUP_HI = 8'b0000_0100,
      PH_PULSE_HI = 8'b0000_1000,
      PH_SETUP_LO = 8'b0001_0000,
      PH_PULSE_LO = 8'b0010_0000,
      PH_SETTLE   = 8'b0100_0000,
      PH_TAIL     = 8'b1000_0000
   } phase_type;

   function automatic logic [7:0] init_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0: b = 8'h33;
         3'd1: b = 8'h32;
         3'd2: b = 8'h28;
         3'd3: b = 8'h0C;
         3'd4: b = 8'h01;
         3'd5: b = 8'h06;
         default: b = 8'h02;
      endcase
      return b;
   endfunction

endpackage

[rtl/core/lcd_4bit_write_sequencer.sv]
// lcd_4bit_write_sequencer: top level, front decode, item queue and pin sequencer
// depends on lws_pkg, lws_front, lws_queue, lws_back
//
//   channel  handshake            payload
//   req      req_valid/req_stall  req_type[2:0] req_value[7:0] req_row
//   rsp      rsp_valid/rsp_stall  rsp_pin_rs rsp_pin_rw rsp_pin_e rsp_pin_data[3:0]
//                                 rsp_busy_res rsp_accepted
//   csr      csr_valid/csr_ready  csr_index[2:0] csr_data[9:0]
//
// one request beat per cycle unless the queue is full (a stalled result fills it); a taken beat passes
// through an entry of the two-entry queue and then the result register
// the back end executes every beat that it pops in its phase counter logic
// reset is synchronous: timing registers return to defaults, sequencer goes idle
// a stalled result holds; requests keep flowing until the queue fills
module lcd_4bit_write_sequencer import lws_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_type,
   input  logic [7:0]           req_value,
   input  logic                 req_row,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_pin_rs,
   output logic                 rsp_pin_rw,
   output logic                 rsp_pin_e,
   output logic [3:0]           rsp_pin_data,
   output logic                 rsp_busy_res,
   output logic                 rsp_accepted,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   logic     q_full, q_push, q_pop, q_valid;
   item_type push_item, head_item;

   lws_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .req_value (req_value),
      .req_row   (req_row),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   lws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (head_item)
   );

   lws_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (head_item),
      .q_pop        (q_pop),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_pin_rs   (rsp_pin_rs),
      .rsp_pin_rw   (rsp_pin_rw),
      .rsp_pin_e    (rsp_pin_e),
      .rsp_pin_data (rsp_pin_data),
      .rsp_busy_res (rsp_busy_res),
      .rsp_accepted (rsp_accepted)
   );

endmodule

[rtl/core/lws_front.sv]
// lws_front: takes request beats and classifies them into queue items
// depends on lws_pkg
module lws_front import lws_pkg::*; (
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_type,
   input  logic [7:0] req_value,
   input  logic       req_row,
   input  logic       q_full,
   output logic       q_push,
   output item_type   q_item
);

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item.op        = OP_NONE;
      q_item.data_byte = req_value;
      q_item.rs        = 1'b0;
      unique case (req_type)
         REQ_TICK: q_item.op = OP_TICK;
         REQ_CMD:  q_item.op = OP_LOAD;
         REQ_CHAR: begin
            q_item.op = OP_LOAD;
            q_item.rs = 1'b1;
         end
         REQ_INIT: q_item.op = OP_INIT;
         REQ_POS: begin
            q_item.op        = OP_LOAD;
            q_item.data_byte = (req_row ? ROW1_BASE : ROW0_BASE) + req_value;
         end
         default: q_item.op = OP_NONE;
      endcase
   end

endmodule

[rtl/core/lws_queue.sv]
// lws_queue: two-entry item queue between front and back
// depends on lws_pkg
module lws_queue import lws_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/core/lws_back.sv]
// lws_back: pin sequencer, timing registers and result register
// depends on lws_pkg
module lws_back import lws_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  item_type             q_item,
   output logic                 q_pop,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_pin_rs,
   output logic                 rsp_pin_rw,
   output logic                 rsp_pin_e,
   output logic [3:0]           rsp_pin_data,
   output logic                 rsp_busy_res,
   output logic                 rsp_accepted
);

   logic [CFG_W-1:0]  cmd_pulse_ff, data_pulse_ff, settle_ff, powerup_ff, tail_ff;
   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] cnt_ff, cnt_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              rs_ff, rs_in;
   logic              e_ff, e_in;
   logic [3:0]        nibble_ff, nibble_in;
   logic [2:0]        idx_ff, idx_in;
   logic              in_init_ff, in_init_in;
   logic              acc;
   logic [CFG_W-1:0]  dur;
   logic [TICK_W:0]   next_cnt;
   logic              done;
   logic [3:0]        next_idx;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_rs_ff, rsp_e_ff, rsp_busy_ff, rsp_acc_ff;
   logic [3:0]        rsp_data_ff;

   assign csr_ready = 1'b1;
   assign q_pop     = q_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      unique case (phase_ff)
         PH_POWERUP:              dur = powerup_ff;
         PH_PULSE_HI, PH_PULSE_LO: dur = rs_ff ? data_pulse_ff : cmd_pulse_ff;
         PH_SETTLE:               dur = settle_ff;
         PH_TAIL:                 dur = tail_ff;
         default:                 dur = CFG_W'(1);
      endcase
   end

   assign next_cnt = {1'b0, cnt_ff} + 1'b1;
   assign done     = !(next_cnt < (TICK_W+1)'(dur));
   assign next_idx = {1'b0, idx_ff} + 1'b1;

   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      out_byte_in = out_byte_ff;
      rs_in       = rs_ff;
      e_in        = e_ff;
      nibble_in   = nibble_ff;
      idx_in      = idx_ff;
      in_init_in  = in_init_ff;
      acc         = 1'b0;
      if (q_pop) begin
         unique case (q_item.op)
            OP_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (!done) begin
                     cnt_in = next_cnt[TICK_W-1:0];
                  end else begin
                     cnt_in = '0;
                     unique case (phase_ff)
                        PH_POWERUP: begin
                           idx_in      = '0;
                           out_byte_in = init_byte(3'd0);
                           rs_in       = 1'b0;
                           e_in        = 1'b0;
                           nibble_in   = 4'(init_byte(3'd0) >> 4);
                           phase_in    = PH_SETUP_HI;
                        end
                        PH_SETUP_HI: begin
                           e_in     = 1'b1;
                           phase_in = PH_PULSE_HI;
                        end
                        PH_PULSE_HI: begin
                           e_in      = 1'b0;
                           nibble_in = out_byte_ff[3:0];
                           phase_in  = PH_SETUP_LO;
                        end
                        PH_SETUP_LO: begin
                           e_in     = 1'b1;
                           phase_in = PH_PULSE_LO;
                        end
                        PH_PULSE_LO: begin
                           e_in     = 1'b0;
                           phase_in = PH_SETTLE;
                        end
                        PH_SETTLE: begin
                           if (!in_init_ff) begin
                              phase_in = PH_IDLE;
                           end else if (next_idx >= 4'(INIT_STEPS)) begin
                              phase_in = PH_TAIL;
                           end else begin
                              idx_in      = next_idx[2:0];
                              out_byte_in = init_byte(next_idx[2:0]);
                              rs_in       = 1'b0;
                              e_in        = 1'b0;
                              nibble_in   = 4'(init_byte(next_idx[2:0]) >> 4);
                              phase_in    = PH_SETUP_HI;
                           end
                        end
                        default: begin
                           in_init_in = 1'b0;
                           idx_in     = '0;
                           phase_in   = PH_IDLE;
                        end
                     endcase
                  end
               end
            end
            OP_LOAD: begin
               if (phase_ff == PH_IDLE) begin
                  acc         = 1'b1;
                  out_byte_in = q_item.data_byte;
                  rs_in       = q_item.rs;
                  e_in        = 1'b0;
                  nibble_in   = q_item.data_byte[7:4];
                  phase_in    = PH_SETUP_HI;
                  cnt_in      = '0;
               end
            end
            OP_INIT: begin
               if (phase_ff == PH_IDLE) begin
                  acc        = 1'b1;
                  in_init_in = 1'b1;
                  idx_in     = '0;
                  e_in       = 1'b0;
                  phase_in   = PH_POWERUP;
                  cnt_in     = '0;
               end
            end
            default: acc = 1'b0;
         endcase
      end
   end

   assign rsp_valid_in = q_pop || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_pulse_ff  <= RST_CMD_PULSE;
         data_pulse_ff <= RST_DATA_PULSE;
         settle_ff     <= RST_SETTLE;
         powerup_ff    <= RST_POWERUP;
         tail_ff       <= RST_INIT_TAIL;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CMD_PULSE:  cmd_pulse_ff  <= csr_data;
            CSR_DATA_PULSE: data_pulse_ff <= csr_data;
            CSR_SETTLE:     settle_ff     <= csr_data;
            CSR_POWERUP:    powerup_ff    <= csr_data;
            CSR_INIT_TAIL:  tail_ff       <= csr_data;
            default:        tail_ff       <= tail_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         out_byte_ff  <= '0;
         rs_ff        <= 1'b0;
         e_ff         <= 1'b0;
         nibble_ff    <= '0;
         idx_ff       <= '0;
         in_init_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         out_byte_ff  <= out_byte_in;
         rs_ff        <= rs_in;
         e_ff         <= e_in;
         nibble_ff    <= nibble_in;
         idx_ff       <= idx_in;
         in_init_ff   <= in_init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register, loaded with the state after each executed beat
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_rs_ff   <= rs_in;
         rsp_e_ff    <= e_in;
         rsp_data_ff <= nibble_in;
         rsp_busy_ff <= (phase_in != PH_IDLE);
         rsp_acc_ff  <= acc;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pin_rs   = rsp_rs_ff;
   assign rsp_pin_rw   = 1'b0;
   assign rsp_pin_e    = rsp_e_ff;
   assign rsp_pin_data = rsp_data_ff;
   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_accepted = rsp_acc_ff;

endmodule
